>>> rtl/sled_pkg.sv
// Shared types, character codes and helpers for the string literal escape decoder.
package sled_pkg;

	localparam int unsigned MAX_RESULTS = 4;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_BS    = 8'h5C;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_N = 8'h6E;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_X = 8'h78;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_UP_U  = 8'h55;

	localparam logic [3:0] DIGITS_BYTE = 4'd2;
	localparam logic [3:0] DIGITS_U4   = 4'd4;
	localparam logic [3:0] DIGITS_U8   = 4'd8;

	localparam logic [31:0] MAX_CODE_POINT = 32'h001F_FFFF;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BODY = 3'd1,
		PH_ESC  = 3'd2,
		PH_HEX  = 3'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_U4   = 2'd2,
		KIND_U8   = 2'd3
	} hex_kind_t;

	typedef enum logic [2:0] {
		FIN_TERM        = 3'd0,
		FIN_NEWLINE     = 3'd1,
		FIN_EOI         = 3'd2,
		FIN_BAD_HEX     = 3'd3,
		FIN_HEX_SHORT   = 3'd4,
		FIN_WIDE_NARROW = 3'd5,
		FIN_CP_RANGE    = 3'd6
	} fin_code_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
		logic       utf8_literal;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       finished;
		logic [2:0] finish_code;
		logic       last;
	} out_t;

	// All results of one request: up to four bytes, then an optional finish.
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] data;
		logic [2:0]                  nbytes;
		logic                        fin;
		fin_code_t                   code;
	} bundle_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] b);
		hex_digit_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.val = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.val = 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.val = 4'(b - 8'h57);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> rtl/string_literal_escape_decoder_top.sv
// Top level of the string literal escape decoder: input register, decoder, result register.
//
// Usage: feed the bytes of one quoted literal on the in channel, one request per
// byte, starting with the opening quote (it becomes the terminator and samples
// utf8_literal). Results come out on the out channel, one per request accepted
// there: decoded bytes, then at most one finish carrying its finish code; last
// marks the final result of each input request. Input bytes that yield nothing
// (opening quote, a backslash, hex digits before the final one) give no result.
// A request accepted into the input register is decoded and its bundle loaded into
// the result register, from which its results are offered. One input request per
// cycle is taken while every request yields at most one result and out_ready is high;
// a request yielding several results (UTF-8 sequences, a stray backslash) holds the
// result register until all are taken, and the input register backs up behind it.
// Reset: arst_n clears all state; the block waits for an opening byte.
// Stall: when out_ready is low the result register holds, then the input
// register fills and in_ready drops; nothing is lost or repeated.
module string_literal_escape_decoder_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sled_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sled_pkg::out_t out_data
);
	import sled_pkg::*;

	in_t     item_s1;
	logic    item_valid_s1;
	logic    free;
	logic    go;
	logic    load;
	bundle_t bundle;

	// Advance the held request once the result register can take its bundle.
	assign go       = item_valid_s1 && free;
	assign in_ready = !item_valid_s1 || go;
	// Drop bundles that carry no result; only the state moves.
	assign load     = go && ((bundle.nbytes != 3'd0) || bundle.fin);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (go) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Hold the payload; capture a new request whenever one is accepted.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	sled_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.bundle (bundle)
	);

	sled_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A bundle keeps presenting results until its last one is taken.
	a_bundle_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("result bundle cut short");

	// A finish is always the final result of its request.
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.finished |-> out_data.last && !out_data.byte_valid)
		else $error("finish not last or carries a byte");

	// Every result is either a byte or a finish.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.byte_valid != out_data.finished))
		else $error("result is neither byte nor finish");

	// An accepted request is held in the input register next cycle.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> item_valid_s1)
		else $error("accepted request lost");

endmodule

>>> rtl/sled_decode.sv
// Literal state machine: decodes one request into its bundle of results.
module sled_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  sled_pkg::in_t    item,
	output sled_pkg::bundle_t bundle
);
	import sled_pkg::*;

	phase_t     phase_q, phase_n;
	logic [7:0] term_q, term_n;
	logic       wide_q, wide_n;
	logic [31:0] acc_q, acc_n;
	logic [3:0] left_q, left_n;
	hex_kind_t  kind_q, kind_n;

	logic [7:0] b;
	logic       eoi;
	logic       is_term;
	logic       is_nl;
	logic       is_bs;
	hex_digit_t hv;

	assign b       = item.data_byte;
	assign eoi     = item.end_of_input;
	assign is_term = (b == term_q);
	assign is_nl   = (b == CH_NL);
	assign is_bs   = (b == CH_BS);
	assign hv      = hex_value(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			term_q  <= '0;
			wide_q  <= 1'b0;
			acc_q   <= '0;
			left_q  <= '0;
			kind_q  <= KIND_NONE;
		end else if (go) begin
			phase_q <= phase_n;
			term_q  <= term_n;
			wide_q  <= wide_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			kind_q  <= kind_n;
		end
	end

	always_comb begin
		phase_n       = phase_q;
		term_n        = term_q;
		wide_n        = wide_q;
		acc_n         = acc_q;
		left_n        = left_q;
		kind_n        = kind_q;
		bundle.data   = '0;
		bundle.nbytes = 3'd0;
		bundle.fin    = 1'b0;
		bundle.code   = FIN_TERM;

		unique case (phase_q)
			PH_IDLE: begin
				if (!eoi) begin
					term_n  = b;
					wide_n  = item.utf8_literal;
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				priority if (eoi) begin
					bundle.fin  = 1'b1;
					bundle.code = FIN_EOI;
					phase_n     = PH_IDLE;
				end else if (is_term) begin
					bundle.fin  = 1'b1;
					bundle.code = FIN_TERM;
					phase_n     = PH_IDLE;
				end else if (is_nl) begin
					bundle.fin  = 1'b1;
					bundle.code = FIN_NEWLINE;
					phase_n     = PH_IDLE;
				end else if (is_bs) begin
					phase_n = PH_ESC;
				end else begin
					bundle.data[0] = b;
					bundle.nbytes  = 3'd1;
				end
			end
			PH_ESC: begin
				phase_n = PH_BODY;
				priority if (eoi) begin
					bundle.data[0] = CH_BS;
					bundle.nbytes  = 3'd1;
					bundle.fin     = 1'b1;
					bundle.code    = FIN_EOI;
					phase_n        = PH_IDLE;
				end else if (b == CH_LOW_R) begin
					bundle.data[0] = CH_CR;
					bundle.nbytes  = 3'd1;
				end else if (b == CH_LOW_N) begin
					bundle.data[0] = CH_NL;
					bundle.nbytes  = 3'd1;
				end else if (b == CH_LOW_T) begin
					bundle.data[0] = CH_TAB;
					bundle.nbytes  = 3'd1;
				end else if (b == CH_SQ || b == CH_DQ) begin
					bundle.data[0] = b;
					bundle.nbytes  = 3'd1;
				end else if (b == CH_LOW_X) begin
					kind_n  = KIND_BYTE;
					left_n  = DIGITS_BYTE;
					acc_n   = '0;
					phase_n = PH_HEX;
				end else if (b == CH_LOW_U || b == CH_UP_U) begin
					if (wide_q) begin
						kind_n  = (b == CH_LOW_U) ? KIND_U4 : KIND_U8;
						left_n  = (b == CH_LOW_U) ? DIGITS_U4 : DIGITS_U8;
						acc_n   = '0;
						phase_n = PH_HEX;
					end else begin
						bundle.fin  = 1'b1;
						bundle.code = FIN_WIDE_NARROW;
						phase_n     = PH_IDLE;
					end
				end else begin
					// Unknown escape: send the backslash, then treat the byte as body.
					bundle.data[0] = CH_BS;
					bundle.nbytes  = 3'd1;
					priority if (is_term) begin
						bundle.fin  = 1'b1;
						bundle.code = FIN_TERM;
						phase_n     = PH_IDLE;
					end else if (is_nl) begin
						bundle.fin  = 1'b1;
						bundle.code = FIN_NEWLINE;
						phase_n     = PH_IDLE;
					end else if (is_bs) begin
						phase_n = PH_ESC;
					end else begin
						bundle.data[1] = b;
						bundle.nbytes  = 3'd2;
					end
				end
			end
			PH_HEX: begin
				priority if (eoi) begin
					bundle.fin  = 1'b1;
					bundle.code = FIN_HEX_SHORT;
					phase_n     = PH_IDLE;
				end else if (!hv.ok) begin
					bundle.fin  = 1'b1;
					bundle.code = FIN_BAD_HEX;
					phase_n     = PH_IDLE;
				end else begin
					acc_n = {acc_q[27:0], hv.val};
					if (left_q != 4'd0) begin
						left_n = left_q - 4'd1;
					end
					if (left_n == 4'd0) begin
						phase_n = PH_BODY;
						priority if (kind_q == KIND_BYTE) begin
							bundle.data[0] = acc_n[7:0];
							bundle.nbytes  = 3'd1;
						end else if (acc_n > MAX_CODE_POINT) begin
							bundle.fin  = 1'b1;
							bundle.code = FIN_CP_RANGE;
							phase_n     = PH_IDLE;
						end else if (acc_n < 32'h0000_0080) begin
							bundle.data[0] = {1'b0, acc_n[6:0]};
							bundle.nbytes  = 3'd1;
						end else if (acc_n < 32'h0000_0800) begin
							bundle.data[0] = {3'b110, acc_n[10:6]};
							bundle.data[1] = {2'b10, acc_n[5:0]};
							bundle.nbytes  = 3'd2;
						end else if (acc_n < 32'h0001_0000) begin
							bundle.data[0] = {4'b1110, acc_n[15:12]};
							bundle.data[1] = {2'b10, acc_n[11:6]};
							bundle.data[2] = {2'b10, acc_n[5:0]};
							bundle.nbytes  = 3'd3;
						end else begin
							bundle.data[0] = {5'b11110, acc_n[20:18]};
							bundle.data[1] = {2'b10, acc_n[17:12]};
							bundle.data[2] = {2'b10, acc_n[11:6]};
							bundle.data[3] = {2'b10, acc_n[5:0]};
							bundle.nbytes  = 3'd4;
						end
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/sled_serial.sv
// Result register: holds one bundle and hands its results out one per cycle while out_ready is high.
module sled_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sled_pkg::bundle_t bundle,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output sled_pkg::out_t    out_data
);
	import sled_pkg::*;

	bundle_t    bnd_q;
	logic       bnd_valid_q;
	logic [1:0] idx_q;
	logic [2:0] total;
	logic       is_last;
	logic       is_byte;
	logic       drain;

	assign total   = bnd_q.nbytes + {2'b00, bnd_q.fin};
	assign is_last = ({1'b0, idx_q} + 3'd1) == total;
	assign is_byte = {1'b0, idx_q} < bnd_q.nbytes;
	assign drain   = bnd_valid_q && out_ready && is_last;
	assign free    = !bnd_valid_q || drain;

	assign out_valid            = bnd_valid_q;
	assign out_data.out_byte    = is_byte ? bnd_q.data[idx_q] : 8'h00;
	assign out_data.byte_valid  = is_byte;
	assign out_data.finished    = !is_byte;
	assign out_data.finish_code = is_byte ? 3'd0 : 3'(bnd_q.code);
	assign out_data.last        = is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			bnd_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (drain) begin
			bnd_valid_q <= 1'b0;
		end else if (bnd_valid_q && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bnd_q <= bundle;
		end
	end

endmodule

>>> verif/tb_string_literal_escape_decoder_top.sv
// Self-checking testbench for the string literal escape decoder top level.
`timescale 1ns / 100ps

module tb_string_literal_escape_decoder_top;
	import sled_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 16;
	localparam int LIMIT_CYCLES = 200_000;
	localparam int RANDOM_ITEMS = 500;
	localparam int REPORT_LIMIT = 10;

	localparam string HEX_LOWER = "0123456789abcdef";
	localparam string HEX_UPPER = "0123456789ABCDEF";

	// One source byte waiting to be sent; hold_for_drain stalls the sender
	// until every outstanding result has been seen.
	typedef struct {
		in_t req;
		bit  hold_for_drain;
	} source_byte_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_ready;
	in_t  in_data   = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	source_byte_t source_bytes[$];
	out_t         pending_results[$];
	out_t         step_results[$];
	bit           next_drain = 1'b0;
	int           mismatch_count = 0;

	// Decoder state as tracked by the predictor.
	phase_t      dec_phase   = PH_IDLE;
	logic [7:0]  term_byte   = '0;
	logic        wide_ok     = 1'b0;
	logic [31:0] hex_acc     = '0;
	logic [3:0]  digits_left = '0;
	hex_kind_t   dec_kind    = KIND_NONE;

	// Sender burst and gap counters.
	int burst_left = 0;
	int gap_left   = 0;

	// Receiver stall pattern: a mode picked each time the 6-bit tick wraps.
	logic [5:0] stall_tick = '0;
	logic [1:0] stall_mode = '0;

	string_literal_escape_decoder_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic int hex_nibble(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return int'(b - "0");
		if (b >= "A" && b <= "F")
			return int'(b - "A") + 10;
		if (b >= "a" && b <= "f")
			return int'(b - "a") + 10;
		return -1;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		out_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		step_results.push_back(r);
	endfunction

	// Close the literal: a finish result, and back to waiting for an opening byte.
	function automatic void emit_finish(input fin_code_t code);
		out_t r;
		r = '0;
		r.finished = 1'b1;
		r.finish_code = code;
		step_results.push_back(r);
		dec_phase = PH_IDLE;
	endfunction

	// Body byte: the terminator test wins over newline and backslash.
	function automatic void decode_body(input logic [7:0] b);
		if (b == term_byte)
			emit_finish(FIN_TERM);
		else if (b == CH_NL)
			emit_finish(FIN_NEWLINE);
		else if (b == CH_BS)
			dec_phase = PH_ESC;
		else
			emit_byte(b);
	endfunction

	function automatic void open_hex(input hex_kind_t kind, input logic [3:0] digits);
		dec_kind = kind;
		digits_left = digits;
		hex_acc = '0;
		dec_phase = PH_HEX;
	endfunction

	// UTF-8 encode up to 0x1FFFFF; reject anything larger.
	function automatic void emit_code_point(input logic [31:0] cp);
		if (cp > MAX_CODE_POINT) begin
			emit_finish(FIN_CP_RANGE);
			return;
		end
		if (cp < 32'h80) begin
			emit_byte(cp[7:0]);
		end else if (cp < 32'h800) begin
			emit_byte({3'b110, cp[10:6]});
			emit_byte({2'b10, cp[5:0]});
		end else if (cp < 32'h10000) begin
			emit_byte({4'b1110, cp[15:12]});
			emit_byte({2'b10, cp[11:6]});
			emit_byte({2'b10, cp[5:0]});
		end else begin
			emit_byte({5'b11110, cp[20:18]});
			emit_byte({2'b10, cp[17:12]});
			emit_byte({2'b10, cp[11:6]});
			emit_byte({2'b10, cp[5:0]});
		end
		dec_phase = PH_BODY;
	endfunction

	// Advance the predictor by one accepted request and queue its results.
	function automatic void decode_request(input in_t req);
		out_t       tail;
		int         nib;
		logic [7:0] b;
		b = req.data_byte;
		step_results.delete();
		case (dec_phase)
			PH_IDLE: begin
				if (!req.end_of_input) begin
					term_byte = b;
					wide_ok = req.utf8_literal;
					dec_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				if (req.end_of_input)
					emit_finish(FIN_EOI);
				else
					decode_body(b);
			end
			PH_ESC: begin
				if (req.end_of_input) begin
					emit_byte(CH_BS);
					emit_finish(FIN_EOI);
				end else begin
					dec_phase = PH_BODY;
					case (b)
						CH_LOW_R: emit_byte(CH_CR);
						CH_LOW_N: emit_byte(CH_NL);
						CH_LOW_T: emit_byte(CH_TAB);
						CH_SQ, CH_DQ: emit_byte(b);
						CH_LOW_X: open_hex(KIND_BYTE, DIGITS_BYTE);
						CH_LOW_U: begin
							if (wide_ok)
								open_hex(KIND_U4, DIGITS_U4);
							else
								emit_finish(FIN_WIDE_NARROW);
						end
						CH_UP_U: begin
							if (wide_ok)
								open_hex(KIND_U8, DIGITS_U8);
							else
								emit_finish(FIN_WIDE_NARROW);
						end
						default: begin
							// Unknown escape: the backslash goes out, the byte is reread.
							emit_byte(CH_BS);
							decode_body(b);
						end
					endcase
				end
			end
			PH_HEX: begin
				nib = hex_nibble(b);
				if (req.end_of_input) begin
					emit_finish(FIN_HEX_SHORT);
				end else if (nib < 0) begin
					emit_finish(FIN_BAD_HEX);
				end else begin
					hex_acc = {hex_acc[27:0], 4'(nib)};
					if (digits_left != 0)
						digits_left = digits_left - 4'd1;
					if (digits_left == 0) begin
						if (dec_kind == KIND_BYTE) begin
							emit_byte(hex_acc[7:0]);
							dec_phase = PH_BODY;
						end else begin
							emit_code_point(hex_acc);
						end
					end
				end
			end
			default: dec_phase = PH_IDLE;
		endcase
		if (step_results.size() != 0) begin
			tail = step_results.pop_back();
			tail.last = 1'b1;
			step_results.push_back(tail);
		end
		foreach (step_results[i])
			pending_results.push_back(step_results[i]);
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of requests with random gaps; predict on acceptance
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left <= 0;
			gap_left <= 0;
			dec_phase = PH_IDLE;
			term_byte = '0;
			wide_ok = 1'b0;
			hex_acc = '0;
			digits_left = '0;
			dec_kind = KIND_NONE;
		end else begin
			if (in_valid && in_ready) begin
				decode_request(in_data);
				void'(source_bytes.pop_front());
			end
			if (in_valid && !in_ready) begin
				// hold: the request stays up unchanged until taken
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (source_bytes.size() != 0 &&
					(!source_bytes[0].hold_for_drain || pending_results.size() == 0)) begin
				in_valid <= 1'b1;
				in_data <= source_bytes[0].req;
				if (burst_left <= 1) begin
					// End of burst: pick the next burst and the gap before it.
					burst_left <= $urandom_range(40, 1);
					gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall on a changing pattern
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		stall_tick <= stall_tick + 6'd1;
		if (stall_tick == '1)
			stall_mode <= 2'($urandom_range(3, 0));
		case (stall_mode)
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom);
			2'd2: out_ready <= (stall_tick[1:0] == 2'd0);
			default: out_ready <= stall_tick[3];
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: compare each accepted result with the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("ERROR %0t: unexpected result byte=%h valid=%b fin=%b code=%0d last=%b",
						$realtime, out_data.out_byte, out_data.byte_valid, out_data.finished,
						out_data.finish_code, out_data.last);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.out_byte !== want.out_byte ||
						out_data.byte_valid !== want.byte_valid ||
						out_data.finished !== want.finished ||
						out_data.finish_code !== want.finish_code ||
						out_data.last !== want.last) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("ERROR %0t: expected byte=%h valid=%b fin=%b code=%0d last=%b, got byte=%h valid=%b fin=%b code=%0d last=%b",
							$realtime, want.out_byte, want.byte_valid, want.finished,
							want.finish_code, want.last, out_data.out_byte, out_data.byte_valid,
							out_data.finished, out_data.finish_code, out_data.last);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_req(input logic [7:0] b, input logic eoi, input logic u8);
		source_byte_t s;
		s.req.data_byte = b;
		s.req.end_of_input = eoi;
		s.req.utf8_literal = u8;
		s.hold_for_drain = next_drain;
		next_drain = 1'b0;
		source_bytes.push_back(s);
	endtask

	// Send the low n nibbles of value, most significant first, in mixed case.
	task automatic queue_hex(input logic [31:0] value, input int n);
		logic [3:0] nib;
		for (int i = n - 1; i >= 0; i--) begin
			nib = value[4 * i +: 4];
			queue_req($urandom_range(1, 0) ? HEX_UPPER[nib] : HEX_LOWER[nib], 1'b0, 1'($urandom));
		end
	endtask

	// Build one literal: mostly well formed with random content, some broken.
	task automatic queue_literal();
		logic [7:0]  term;
		logic [7:0]  b;
		logic        u8;
		logic        long_form;
		logic [31:0] cp;
		int          pick;
		int          nseg;
		pick = $urandom_range(15, 0);
		if (pick < 7)
			term = CH_DQ;
		else if (pick < 13)
			term = CH_SQ;
		else if (pick == 13)
			term = 8'($urandom);
		else if (pick == 14)
			term = CH_NL;
		else
			term = CH_BS;
		u8 = ($urandom_range(3, 0) != 0);
		queue_req(term, 1'b0, u8);
		nseg = $urandom_range(10, 0);
		repeat (nseg) begin
			pick = $urandom_range(19, 0);
			if (pick <= 7) begin
				// plain byte that neither ends the literal nor starts an escape
				do
					b = 8'($urandom);
				while (b == term || b == CH_NL || b == CH_BS);
				queue_req(b, 1'b0, 1'($urandom));
			end else if (pick <= 10) begin
				queue_req(CH_BS, 1'b0, 1'($urandom));
				case ($urandom_range(4, 0))
					0: b = CH_LOW_R;
					1: b = CH_LOW_N;
					2: b = CH_LOW_T;
					3: b = CH_SQ;
					default: b = CH_DQ;
				endcase
				queue_req(b, 1'b0, 1'($urandom));
			end else if (pick <= 12) begin
				queue_req(CH_BS, 1'b0, 1'($urandom));
				queue_req(CH_LOW_X, 1'b0, 1'($urandom));
				queue_hex($urandom_range(255, 0), 2);
			end else if (pick <= 16) begin
				long_form = (pick >= 15);
				queue_req(CH_BS, 1'b0, 1'($urandom));
				if (!u8 && $urandom_range(7, 0) != 0) begin
					// keep most narrow literals alive: fall back to a byte escape
					queue_req(CH_LOW_X, 1'b0, 1'($urandom));
					queue_hex($urandom_range(255, 0), 2);
				end else begin
					queue_req(long_form ? CH_UP_U : CH_LOW_U, 1'b0, 1'($urandom));
					if (!u8)
						return;
					case ($urandom_range(long_form ? 5 : 2, 0))
						0: cp = $urandom_range(32'h7F, 0);
						1: cp = $urandom_range(32'h7FF, 32'h80);
						2: cp = $urandom_range(32'hFFFF, 32'h800);
						3: cp = $urandom_range(MAX_CODE_POINT, 32'h10000);
						4: cp = MAX_CODE_POINT + 32'($urandom_range(1, 0));
						default: cp = $urandom;
					endcase
					queue_hex(cp, long_form ? 8 : 4);
					if (cp > MAX_CODE_POINT)
						return;
				end
			end else if (pick == 17) begin
				// unknown escape: backslash sent, the byte read again
				queue_req(CH_BS, 1'b0, 1'($urandom));
				do
					b = 8'($urandom);
				while (b inside {CH_LOW_R, CH_LOW_N, CH_LOW_T, CH_SQ, CH_DQ,
						CH_LOW_X, CH_LOW_U, CH_UP_U});
				queue_req(b, 1'b0, 1'($urandom));
				if (b == term || b == CH_NL)
					return;
			end else begin
				// broken hex: a stray byte or end of input among the digits
				queue_req(CH_BS, 1'b0, 1'($urandom));
				long_form = u8 && $urandom_range(1, 0);
				queue_req(long_form ? CH_UP_U : CH_LOW_X, 1'b0, 1'($urandom));
				queue_hex($urandom, $urandom_range(long_form ? 7 : 1, 0));
				if (pick == 18) begin
					if ($urandom_range(3, 0) == 0) begin
						b = ($urandom_range(1, 0) != 0) ? term : CH_NL;
					end else begin
						do
							b = 8'($urandom);
						while (hex_nibble(b) >= 0);
					end
					queue_req(b, 1'b0, 1'($urandom));
				end else begin
					queue_req(8'($urandom), 1'b1, 1'($urandom));
				end
				return;
			end
		end
		pick = $urandom_range(9, 0);
		if (pick <= 6) begin
			queue_req(term, 1'b0, 1'($urandom));
		end else if (pick == 7) begin
			queue_req(CH_NL, 1'b0, 1'($urandom));
		end else begin
			if (pick == 9)
				queue_req(CH_BS, 1'b0, 1'($urandom));
			queue_req(8'($urandom), 1'b1, 1'($urandom));
		end
	endtask

	initial begin
		int half_mark;
		// end of input while idle is ignored
		queue_req(8'hA5, 1'b1, 1'b0);
		// UTF-8 literal: extreme bytes, a tab escape, an unknown escape, bad hex
		queue_req(CH_DQ, 1'b0, 1'b1);
		queue_req(8'h00, 1'b0, 1'b0);
		queue_req(8'hFF, 1'b0, 1'b1);
		queue_req(CH_BS, 1'b0, 1'b0);
		queue_req(CH_LOW_T, 1'b0, 1'b0);
		queue_req(CH_BS, 1'b0, 1'b0);
		queue_req("q", 1'b0, 1'b0);
		queue_req(CH_BS, 1'b0, 1'b0);
		queue_req(CH_LOW_X, 1'b0, 1'b0);
		queue_req("4", 1'b0, 1'b0);
		queue_req("g", 1'b0, 1'b0);
		// newline as terminator, then a wide escape in a narrow literal
		queue_req(CH_NL, 1'b0, 1'b0);
		queue_req("a", 1'b0, 1'b0);
		queue_req(CH_BS, 1'b0, 1'b0);
		queue_req(CH_LOW_U, 1'b0, 1'b1);
		// backslash as terminator closes at once
		queue_req(CH_BS, 1'b0, 1'b1);
		queue_req(CH_BS, 1'b0, 1'b0);
		// newline ends a literal left unconsumed
		queue_req("x", 1'b0, 1'b0);
		queue_req(CH_NL, 1'b0, 1'b0);
		// end of input right after a backslash
		queue_req(CH_SQ, 1'b0, 1'b1);
		queue_req(CH_BS, 1'b0, 1'b0);
		queue_req(8'h00, 1'b1, 1'b0);
		// end of input in the body
		queue_req(CH_DQ, 1'b0, 1'b0);
		queue_req(8'hFF, 1'b1, 1'b1);

		// Random part: drain once before it starts and once halfway.
		next_drain = 1'b1;
		half_mark = source_bytes.size() + RANDOM_ITEMS / 2;
		while (source_bytes.size() < RANDOM_ITEMS + 25) begin
			if (source_bytes.size() >= half_mark) begin
				next_drain = 1'b1;
				half_mark = RANDOM_ITEMS * 4;
			end
			queue_literal();
			if ($urandom_range(15, 0) == 0)
				queue_req(8'($urandom), 1'b1, 1'($urandom));
		end

		// Wait for every request to go in and every result to come out.
		@(posedge arst_n);
		while (source_bytes.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog on a hung handshake.
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("TEST FAILED");
		$finish;
	end

endmodule
